// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/core/phuw_pkg.sv
// ----------------------------------------------------------------------------
// Phase unwrapper package
// Field widths, register indexes, defaults and controller/datapath interface.
// ----------------------------------------------------------------------------
package phuw_pkg;

    localparam int PHASE_W   = 13;
    localparam int OFF_W     = 10;
    localparam int OUT_W     = 22;
    localparam int DIM_W     = 9;
    localparam int THR_W     = 13;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_WIDTH_DEF   = 256;
    localparam int MAX_HEIGHT_DEF  = 256;
    localparam int TURN_COUNTS_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 2'd2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = 9'd256;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = 9'd256;
    localparam logic [THR_W-1:0] JUMP_THRESHOLD_RST = 13'd3072;

    typedef struct packed {
        logic load;          // write sample, advance load position
        logic read_issue;    // present readout address to the stores
        logic read_out;      // form result from store data
        logic init_base;     // latch center row base address
        logic write_center;  // zero center offset, rewind segment walk
        logic seg_setup;     // load segment start and step count
        logic seg_next;      // advance to next segment
        logic fetch_rd;      // read segment start pixel
        logic fetch_latch;   // latch segment start pixel
        logic step_rd;       // read current pixel
        logic step_wr;       // compare, write offset, advance
        logic finish;        // mark frame complete
    } t_cmd;

    typedef struct packed {
        logic load_last;
        logic seg_zero;
        logic last_seg;
        logic last_step;
    } t_status;

endpackage

// File: rtl/core/phase_unwrap_row_column.sv
// ----------------------------------------------------------------------------
// Row-column phase unwrapper
// Loads a wrapped phase frame, unwraps it from the center pixel and reads it
// out with the turn offsets added.
// ----------------------------------------------------------------------------
// A load (mode 0) leaves busy low, except after the last sample of the
// frame: busy then stays high for the offset walk. Each pixel costs a
// registered store read and then a compare-and-write, and each nonempty row or
// column segment adds a fetch of its start pixel. A read (mode 1) raises busy
// while the stores are read, so a new item is taken only once busy is low
// again; the result strobes on o_valid for one cycle, as busy returns low,
// since the receiver cannot stall. Reads before a frame is complete return
// all zero fields. No clearing pass runs after reset: store contents are
// only used once a whole frame has been loaded.
`include "assert_macros.svh"

module phase_unwrap_row_column
    import phuw_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int TURN_COUNTS = TURN_COUNTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_mode,
    input  logic signed [PHASE_W-1:0] i_phase_sample,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output logic                      o_valid,
    output logic signed [OUT_W-1:0]   o_unwrapped_phase,
    output logic                      o_frame_ready,
    output logic                      o_last_of_frame
);

    t_cmd    cmd;
    t_status status;

    phuw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    phuw_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .TURN_COUNTS (TURN_COUNTS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_phase_sample    (i_phase_sample),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_unwrapped_phase (o_unwrapped_phase),
        .o_frame_ready     (o_frame_ready),
        .o_last_of_frame   (o_last_of_frame)
    );

    `ASSERT_PROP(a_read_goes_busy, i_clk, i_rst_n, (start && !busy && i_mode) |=> busy, "read item did not hold busy")
    `ASSERT_PROP(a_valid_after_busy, i_clk, i_rst_n, o_valid |-> $past(busy), "result strobe without a read in progress")
    `ASSERT_NEVER(a_last_needs_ready, i_clk, i_rst_n, o_valid && o_last_of_frame && !o_frame_ready, "last pixel flagged on a not-ready result")
    `ASSERT_NEVER(a_not_ready_zero, i_clk, i_rst_n, o_valid && !o_frame_ready && (o_unwrapped_phase != '0), "not-ready result carries data")

endmodule

// File: rtl/core/phuw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module phuw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/phuw_ctrl.sv
// ----------------------------------------------------------------------------
// Phase unwrapper controller
// Sequences loading, the row-column offset walk and readout.
// ----------------------------------------------------------------------------
module phuw_ctrl
    import phuw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_mode,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_CENTER,
        S_SEG,
        S_FETCH,
        S_LATCH,
        S_STEP_RD,
        S_STEP_WR,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (!i_mode) begin
                        o_cmd.load = 1'b1;
                        if (i_status.load_last) begin
                            n_state = S_BASE;
                        end
                    end else begin
                        o_cmd.read_issue = 1'b1;
                        n_state          = S_READ;
                    end
                end
            end
            S_BASE: begin
                o_cmd.init_base = 1'b1;
                n_state         = S_CENTER;
            end
            S_CENTER: begin
                o_cmd.write_center = 1'b1;
                n_state            = S_SEG;
            end
            S_SEG: begin
                if (i_status.seg_zero) begin
                    // skip empty segment
                    if (i_status.last_seg) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.seg_next = 1'b1;
                    end
                end else begin
                    o_cmd.seg_setup = 1'b1;
                    n_state         = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch_rd = 1'b1;
                n_state        = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.fetch_latch = 1'b1;
                n_state           = S_STEP_RD;
            end
            S_STEP_RD: begin
                o_cmd.step_rd = 1'b1;
                n_state       = S_STEP_WR;
            end
            S_STEP_WR: begin
                o_cmd.step_wr = 1'b1;
                if (i_status.last_step) begin
                    if (i_status.last_seg) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.seg_next = 1'b1;
                        n_state        = S_SEG;
                    end
                end else begin
                    n_state = S_STEP_RD;
                end
            end
            S_READ: begin
                o_cmd.read_out = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// File: rtl/core/phuw_datapath.sv
// ----------------------------------------------------------------------------
// Phase unwrapper datapath
// Sample and offset stores, address counters, wrap compare and result stage.
// ----------------------------------------------------------------------------
module phuw_datapath
    import phuw_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int TURN_COUNTS = TURN_COUNTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic signed [PHASE_W-1:0]  i_phase_sample,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output logic                       o_valid,
    output logic signed [OUT_W-1:0]    o_unwrapped_phase,
    output logic                       o_frame_ready,
    output logic                       o_last_of_frame
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int SCW   = (XW > YW) ? XW : YW;
    localparam int TW    = $clog2(TURN_COUNTS + 1) + 1;
    localparam int SW    = (OFF_W + TW + 1 > OUT_W) ? OFF_W + TW + 1 : OUT_W;
    localparam int DFW   = PHASE_W + 2;

    localparam logic signed [SW-1:0]    TURN_S  = SW'(TURN_COUNTS);
    localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
    localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

    typedef enum logic [1:0] {
        SEG_LEFT,
        SEG_RIGHT,
        SEG_UP,
        SEG_DOWN
    } t_seg;

    // configuration
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [THR_W-1:0] r_thr;
    logic [DW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;
    logic [XW-1:0]    cx, w_last;
    logic [YW-1:0]    cy, h_last;

    // load and readout positions
    logic          r_complete;
    logic [AW-1:0] r_ld_addr, r_rd_addr;
    logic [XW-1:0] r_ld_x, r_rd_x;
    logic [YW-1:0] r_ld_y, r_rd_y;
    logic [AW-1:0] ld_addr;
    logic [XW-1:0] ld_x;
    logic [YW-1:0] ld_y;
    logic          ld_last, rd_last;

    // offset walk
    logic [AW-1:0]             r_row_base, r_nb_addr, cur_addr, center_addr;
    logic [YW+DW-1:0]          base_prod;
    t_seg                      r_seg;
    logic [XW-1:0]             r_col;
    logic [SCW-1:0]            r_steps, seg_steps;
    logic signed [PHASE_W-1:0] r_nb_ph;
    logic signed [OFF_W-1:0]   r_nb_off, new_off;
    logic signed [DFW-1:0]     diff, thr_s;

    // stores
    logic [AW-1:0]             raddr, off_waddr;
    logic                      off_we;
    logic [OFF_W-1:0]          off_wdata, off_rdata;
    logic [PHASE_W-1:0]        ph_rdata;
    logic signed [PHASE_W-1:0] ph_rd;
    logic signed [OFF_W-1:0]   off_rd;
    logic signed [SW-1:0]      sum;

    logic                    r_valid, r_ready, r_last;
    logic signed [OUT_W-1:0] r_out;

    // clamp frame size into 1..MAX
    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = DW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
    end

    assign cx     = XW'(w_eff >> 1);
    assign cy     = YW'(h_eff >> 1);
    assign w_last = XW'(w_eff - DW'(1));
    assign h_last = YW'(h_eff - HW'(1));

    // a load after a complete frame starts over at pixel 0
    assign ld_addr = r_complete ? '0 : r_ld_addr;
    assign ld_x    = r_complete ? '0 : r_ld_x;
    assign ld_y    = r_complete ? '0 : r_ld_y;
    assign ld_last = (ld_x == w_last) && (ld_y == h_last);
    assign rd_last = (r_rd_x == w_last) && (r_rd_y == h_last);

    assign base_prod   = (YW+DW)'(cy) * (YW+DW)'(w_eff);
    assign center_addr = r_row_base + AW'(cx);

    always_comb begin
        case (r_seg)
            SEG_LEFT:  seg_steps = SCW'(cx);
            SEG_RIGHT: seg_steps = SCW'(w_last - cx);
            SEG_UP:    seg_steps = SCW'(cy);
            SEG_DOWN:  seg_steps = SCW'(h_last - cy);
            default:   seg_steps = '0;
        endcase
        case (r_seg)
            SEG_LEFT:  cur_addr = r_nb_addr - AW'(1);
            SEG_RIGHT: cur_addr = r_nb_addr + AW'(1);
            SEG_UP:    cur_addr = r_nb_addr - AW'(w_eff);
            SEG_DOWN:  cur_addr = r_nb_addr + AW'(w_eff);
            default:   cur_addr = r_nb_addr;
        endcase
    end

    assign o_status.load_last = ld_last;
    assign o_status.seg_zero  = (seg_steps == '0);
    assign o_status.last_seg  = (r_seg == SEG_DOWN) && (r_col == w_last);
    assign o_status.last_step = (r_steps == SCW'(1));

    assign ph_rd  = $signed(ph_rdata);
    assign off_rd = $signed(off_rdata);

    // wrap compare against the neighbor, saturating offset
    assign diff  = DFW'(ph_rd) - DFW'(r_nb_ph);
    assign thr_s = $signed({2'b00, r_thr});

    always_comb begin
        new_off = r_nb_off;
        if (diff > thr_s) begin
            if (r_nb_off != OFF_MIN) begin
                new_off = r_nb_off - OFF_W'(1);
            end
        end else if (-diff > thr_s) begin
            if (r_nb_off != OFF_MAX) begin
                new_off = r_nb_off + OFF_W'(1);
            end
        end
    end

    always_comb begin
        if (i_cmd.read_issue) begin
            raddr = r_rd_addr;
        end else if (i_cmd.step_rd) begin
            raddr = cur_addr;
        end else begin
            raddr = r_nb_addr;
        end
    end

    assign off_we    = i_cmd.write_center | i_cmd.step_wr;
    assign off_waddr = i_cmd.write_center ? center_addr : cur_addr;
    assign off_wdata = i_cmd.write_center ? '0 : new_off;

    phuw_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (DEPTH)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (ld_addr),
        .i_wdata (i_phase_sample),
        .i_raddr (raddr),
        .o_rdata (ph_rdata)
    );

    phuw_ram #(
        .WIDTH (OFF_W),
        .DEPTH (DEPTH)
    ) u_offset_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (off_waddr),
        .i_wdata (off_wdata),
        .i_raddr (raddr),
        .o_rdata (off_rdata)
    );

    assign sum = SW'(ph_rd) + SW'(off_rd) * TURN_S;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= FRAME_WIDTH_RST;
            r_cfg_h    <= FRAME_HEIGHT_RST;
            r_thr      <= JUMP_THRESHOLD_RST;
            r_complete <= 1'b0;
            r_ld_addr  <= '0;
            r_ld_x     <= '0;
            r_ld_y     <= '0;
            r_rd_addr  <= '0;
            r_rd_x     <= '0;
            r_rd_y     <= '0;
            r_seg      <= SEG_LEFT;
            r_col      <= '0;
            r_steps    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.read_out;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_cfg_w    <= DIM_W'(i_cfg_data);
                        r_complete <= 1'b0;
                        r_ld_addr  <= '0;
                        r_ld_x     <= '0;
                        r_ld_y     <= '0;
                        r_rd_addr  <= '0;
                        r_rd_x     <= '0;
                        r_rd_y     <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_cfg_h    <= DIM_W'(i_cfg_data);
                        r_complete <= 1'b0;
                        r_ld_addr  <= '0;
                        r_ld_x     <= '0;
                        r_ld_y     <= '0;
                        r_rd_addr  <= '0;
                        r_rd_x     <= '0;
                        r_rd_y     <= '0;
                    end
                    CFG_JUMP_THRESHOLD: begin
                        r_thr <= THR_W'(i_cfg_data);
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_complete <= 1'b0;
                r_rd_addr  <= '0;
                r_rd_x     <= '0;
                r_rd_y     <= '0;
                r_ld_addr  <= ld_addr + AW'(1);
                if (ld_x == w_last) begin
                    r_ld_x <= '0;
                    r_ld_y <= ld_y + YW'(1);
                end else begin
                    r_ld_x <= ld_x + XW'(1);
                    r_ld_y <= ld_y;
                end
            end
            if (i_cmd.read_out && r_complete) begin
                if (rd_last) begin
                    r_rd_addr <= '0;
                    r_rd_x    <= '0;
                    r_rd_y    <= '0;
                end else begin
                    r_rd_addr <= r_rd_addr + AW'(1);
                    if (r_rd_x == w_last) begin
                        r_rd_x <= '0;
                        r_rd_y <= r_rd_y + YW'(1);
                    end else begin
                        r_rd_x <= r_rd_x + XW'(1);
                    end
                end
            end
            if (i_cmd.write_center) begin
                r_seg <= SEG_LEFT;
                r_col <= '0;
            end
            if (i_cmd.seg_setup) begin
                r_steps <= seg_steps;
            end
            if (i_cmd.step_wr) begin
                r_steps <= r_steps - SCW'(1);
            end
            if (i_cmd.seg_next) begin
                case (r_seg)
                    SEG_LEFT: begin
                        r_seg <= SEG_RIGHT;
                    end
                    SEG_RIGHT: begin
                        r_seg <= SEG_UP;
                        r_col <= '0;
                    end
                    SEG_UP: begin
                        if (r_col == w_last) begin
                            r_seg <= SEG_DOWN;
                            r_col <= '0;
                        end else begin
                            r_col <= r_col + XW'(1);
                        end
                    end
                    default: begin
                        r_col <= r_col + XW'(1);
                    end
                endcase
            end
            if (i_cmd.finish) begin
                r_complete <= 1'b1;
                r_rd_addr  <= '0;
                r_rd_x     <= '0;
                r_rd_y     <= '0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_base) begin
            r_row_base <= AW'(base_prod);
        end
        if (i_cmd.seg_setup) begin
            if (r_seg == SEG_LEFT || r_seg == SEG_RIGHT) begin
                r_nb_addr <= r_row_base + AW'(cx);
            end else begin
                r_nb_addr <= r_row_base + AW'(r_col);
            end
        end
        if (i_cmd.fetch_latch) begin
            r_nb_ph  <= ph_rd;
            r_nb_off <= off_rd;
        end
        if (i_cmd.step_wr) begin
            // current pixel becomes the next neighbor
            r_nb_addr <= cur_addr;
            r_nb_ph   <= ph_rd;
            r_nb_off  <= new_off;
        end
        if (i_cmd.read_out) begin
            if (r_complete) begin
                r_out   <= OUT_W'(sum);
                r_ready <= 1'b1;
                r_last  <= rd_last;
            end else begin
                r_out   <= '0;
                r_ready <= 1'b0;
                r_last  <= 1'b0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_unwrapped_phase = r_out;
    assign o_frame_ready     = r_ready;
    assign o_last_of_frame   = r_last;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Row-column phase unwrapper testbench
// Loads wrapped phase frames of many sizes and thresholds, reads them back
// and compares every result, field by field, with an in-bench predictor that
// tracks the sample store, the offsets and the load/readout counters.
// ----------------------------------------------------------------------------
module tb_top;
    import phuw_pkg::*;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam logic signed [PHASE_W-1:0] PHASE_MAX = 13'h0FFF;
    localparam logic signed [PHASE_W-1:0] PHASE_MIN = 13'h1000;
    localparam int STORE_DEPTH    = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int OFFSET_HI      = 511;
    localparam int OFFSET_LO      = -512;
    localparam int PAD_W          = CFG_W - DIM_W;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [OUT_W-1:0] phase;
        logic                    ready;
        logic                    last;
    } t_pixel;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic                      i_mode = MODE_LOAD;
    logic signed [PHASE_W-1:0] i_phase_sample = '0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [CFG_W-1:0]          i_cfg_data = '0;
    logic                      o_valid;
    logic signed [OUT_W-1:0]   o_unwrapped_phase;
    logic                      o_frame_ready;
    logic                      o_last_of_frame;

    // predictor state
    logic signed [PHASE_W-1:0] phase_mem [STORE_DEPTH];
    logic signed [OFF_W-1:0]   offset_mem [STORE_DEPTH];
    int                        loaded_px = 0;
    int                        readout_px = 0;
    bit                        frame_held = 1'b0;
    logic [DIM_W-1:0]          width_reg = FRAME_WIDTH_RST;
    logic [DIM_W-1:0]          height_reg = FRAME_HEIGHT_RST;
    logic [THR_W-1:0]          thresh_reg = JUMP_THRESHOLD_RST;

    t_pixel pending_pixels [$];
    int     error_count = 0;
    int     sender_idle_pct = 0;
    int     quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    phase_unwrap_row_column #(
        .MAX_WIDTH   (MAX_WIDTH_DEF),
        .MAX_HEIGHT  (MAX_HEIGHT_DEF),
        .TURN_COUNTS (TURN_COUNTS_DEF)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_mode            (i_mode),
        .i_phase_sample    (i_phase_sample),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_unwrapped_phase (o_unwrapped_phase),
        .o_frame_ready     (o_frame_ready),
        .o_last_of_frame   (o_last_of_frame)
    );

    function automatic int clamp_dim(logic [DIM_W-1:0] v, int lim);
        if (v == 0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    function automatic int frame_pixels();
        return clamp_dim(width_reg, MAX_WIDTH_DEF) * clamp_dim(height_reg, MAX_HEIGHT_DEF);
    endfunction

    // copy the neighbor's offset, step it by one turn on a jump past the threshold
    function automatic void carry_offset(int cur, int nb);
        int off;
        int d;
        off = offset_mem[nb];
        d = phase_mem[cur] - phase_mem[nb];
        if (d > int'(thresh_reg)) off--;
        else if (-d > int'(thresh_reg)) off++;
        if (off > OFFSET_HI) off = OFFSET_HI;
        if (off < OFFSET_LO) off = OFFSET_LO;
        offset_mem[cur] = OFF_W'(off);
    endfunction

    function automatic void unwrap_walk();
        int w;
        int h;
        int cx;
        int cy;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        cx = w / 2;
        cy = h / 2;
        offset_mem[cx + w * cy] = '0;
        for (int x = cx; x > 0; x--) carry_offset((x - 1) + w * cy, x + w * cy);
        for (int x = cx + 1; x < w; x++) carry_offset(x + w * cy, (x - 1) + w * cy);
        for (int x = 0; x < w; x++)
            for (int y = cy; y > 0; y--) carry_offset(x + w * (y - 1), x + w * y);
        for (int x = 0; x < w; x++)
            for (int y = cy + 1; y < h; y++) carry_offset(x + w * y, x + w * (y - 1));
    endfunction

    function automatic void load_sample(logic signed [PHASE_W-1:0] s);
        int total;
        total = frame_pixels();
        if (frame_held) begin
            loaded_px = 0;
            readout_px = 0;
            frame_held = 1'b0;
        end
        if (loaded_px < total) phase_mem[loaded_px] = s;
        loaded_px++;
        if (loaded_px >= total) begin
            unwrap_walk();
            frame_held = 1'b1;
            readout_px = 0;
            loaded_px = total;
        end
    endfunction

    function automatic void read_pixel();
        t_pixel r;
        int     total;
        int     v;
        total = frame_pixels();
        r = '0;
        if (frame_held && readout_px < total) begin
            v = int'(phase_mem[readout_px]) + int'(offset_mem[readout_px]) * TURN_COUNTS_DEF;
            r.phase = OUT_W'(v);
            r.ready = 1'b1;
            r.last = (readout_px + 1 == total);
            readout_px = r.last ? 0 : readout_px + 1;
        end
        pending_pixels.push_back(r);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT: begin
                if (idx == CFG_FRAME_WIDTH) width_reg = data[DIM_W-1:0];
                else height_reg = data[DIM_W-1:0];
                loaded_px = 0;
                readout_px = 0;
                frame_held = 1'b0;
            end
            CFG_JUMP_THRESHOLD: thresh_reg = data[THR_W-1:0];
            default: ;
        endcase
    endfunction

    // size value with random junk in the bits above the register
    function automatic logic [CFG_W-1:0] size_word(int size);
        return {PAD_W'($urandom), DIM_W'(size)};
    endfunction

    task automatic send_item(input logic mode, input logic signed [PHASE_W-1:0] sample);
        if ($urandom_range(1, 100) <= sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(1, 100) <= sender_idle_pct);
        end
        start <= 1'b1;
        i_mode <= mode;
        i_phase_sample <= sample;
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        if (mode == MODE_LOAD) load_sample(sample);
        else read_pixel();
    endtask

    task automatic read_items(input int n);
        for (int k = 0; k < n; k++) send_item(MODE_READ, PHASE_W'($urandom));
    endtask

    // hold off until every result is in and the offset walk is done
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    // wrapped ramp with noise, some random and some extreme samples, reads mixed in when noisy
    task automatic load_frame(input int n_px, input bit noisy, inout int items);
        int                        acc;
        int                        step;
        logic signed [PHASE_W-1:0] sample;
        acc = $urandom;
        step = int'($urandom_range(0, 6000)) - 3000;
        for (int k = 0; k < n_px; k++) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                read_items(1);
                items++;
            end
            case ($urandom_range(0, 9))
                0: sample = PHASE_W'($urandom);
                1: sample = $urandom_range(0, 1) ? PHASE_MAX : PHASE_MIN;
                default: begin
                    acc += step + int'($urandom_range(0, 400)) - 200;
                    sample = PHASE_W'(acc);
                end
            endcase
            send_item(MODE_LOAD, sample);
            items++;
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_threshold();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return CFG_W'(8191);
            2: return CFG_W'(JUMP_THRESHOLD_RST);
            3: return CFG_W'($urandom_range(0, 8191));
            default: return CFG_W'($urandom_range(1000, 5000));
        endcase
    endfunction

    task automatic test_read_before_frame();
        read_items(1);
        write_reg(CFG_UNUSED_INDEX, 13'h1FFF);
        write_reg(CFG_FRAME_WIDTH, size_word(511));
        write_reg(CFG_FRAME_HEIGHT, size_word(300));
        read_items(1);
    endtask

    // steps of exactly the threshold and one past it, both signs, and field extremes
    task automatic test_small_frame();
        logic signed [PHASE_W-1:0] row_major [9];
        row_major = '{PHASE_MAX, 13'sd3073, 13'sd0,
                      PHASE_MIN, 13'sd0, 13'sd3072,
                      -13'sd1, -13'sd3073, PHASE_MAX};
        write_reg(CFG_JUMP_THRESHOLD, CFG_W'(JUMP_THRESHOLD_RST));
        write_reg(CFG_FRAME_WIDTH, size_word(3));
        write_reg(CFG_FRAME_HEIGHT, size_word(3));
        for (int k = 0; k < 9; k++) begin
            if (k == 4) read_items(1);
            send_item(MODE_LOAD, row_major[k]);
        end
        // run one past the end to wrap the readout
        read_items(10);
    endtask

    task automatic test_held_frame();
        write_reg(CFG_JUMP_THRESHOLD, '0);
        read_items(2);
        send_item(MODE_LOAD, 13'sd100);
        read_items(1);
    endtask

    task automatic test_single_pixel();
        write_reg(CFG_FRAME_WIDTH, size_word(1));
        write_reg(CFG_FRAME_HEIGHT, size_word(0));
        send_item(MODE_LOAD, PHASE_MAX);
        read_items(2);
        send_item(MODE_LOAD, PHASE_MIN);
        read_items(1);
    endtask

    // full-width row, zero height acting as one row
    task automatic test_extreme_sizes();
        int items;
        items = 0;
        write_reg(CFG_FRAME_WIDTH, size_word(MAX_WIDTH_DEF));
        write_reg(CFG_FRAME_HEIGHT, size_word(0));
        write_reg(CFG_JUMP_THRESHOLD, '0);
        load_frame(frame_pixels(), 1'b0, items);
        read_items(64);
    endtask

    task automatic test_random_frames(input int n_items);
        int items;
        int total;
        int n_reads;
        items = 0;
        while (items < n_items) begin
            if (items == 0 || $urandom_range(0, 1) == 0) begin
                write_reg(CFG_FRAME_WIDTH, size_word($urandom_range(0, 9) == 0 ?
                          $urandom_range(6, 9) : $urandom_range(0, 5)));
                write_reg(CFG_FRAME_HEIGHT, size_word($urandom_range(0, 9) == 0 ?
                          $urandom_range(6, 9) : $urandom_range(0, 5)));
            end
            if ($urandom_range(0, 2) == 0) write_reg(CFG_JUMP_THRESHOLD, pick_threshold());
            total = frame_pixels();
            // drop a partly loaded frame by rewriting the height
            if (total > 1 && $urandom_range(0, 9) == 0) begin
                load_frame($urandom_range(1, total - 1), 1'b0, items);
                write_reg(CFG_FRAME_HEIGHT, size_word(height_reg));
            end
            load_frame(total, 1'b1, items);
            if ($urandom_range(0, 4) == 0) write_reg(CFG_JUMP_THRESHOLD, pick_threshold());
            n_reads = ($urandom_range(0, 4) == 0) ? $urandom_range(0, total)
                                                 : total + $urandom_range(0, 2);
            read_items(n_reads);
            items += n_reads;
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
    endtask

    always @(negedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                $error("result with no item waiting: unwrapped_phase %0d", o_unwrapped_phase);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_unwrapped_phase !== want.phase) begin
                    $error("unwrapped_phase: expected %0d, got %0d", want.phase,
                           o_unwrapped_phase);
                    error_count++;
                end
                if (o_frame_ready !== want.ready) begin
                    $error("frame_ready: expected %0d, got %0d", want.ready, o_frame_ready);
                    error_count++;
                end
                if (o_last_of_frame !== want.last) begin
                    $error("last_of_frame: expected %0d, got %0d", want.last,
                           o_last_of_frame);
                    error_count++;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(negedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("watchdog: no activity for %0d cycles, %0d results pending",
                       quiet_cycles, pending_pixels.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 0;
        test_read_before_frame();
        test_small_frame();
        test_held_frame();
        test_single_pixel();
        sender_idle_pct = 33;
        test_extreme_sizes();
        sender_idle_pct = 0;
        test_random_frames(20);
        sender_idle_pct = 75;
        test_random_frames(20);
        sender_idle_pct = 33;
        test_random_frames(20);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: phase_unwrap_row_column.f
+incdir+rtl/core
rtl/core/phuw_pkg.sv
rtl/core/phuw_ram.sv
rtl/core/phuw_ctrl.sv
rtl/core/phuw_datapath.sv
rtl/core/phase_unwrap_row_column.sv
tb/sv/tb_top.sv
